// ===== rtl/rmq_pkg.sv =====
package rmq_pkg;

  localparam int unsigned FIELD_W   = 18;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned MAG_W     = FIELD_W + 1;

  localparam logic signed [FIELD_W-1:0] SAT_MAX = 18'sh1FFFF;
  localparam logic signed [FIELD_W-1:0] SAT_MIN = 18'sh20000;

  // which component takes the root term, or the positive trace case
  localparam logic [1:0] SEL_X     = 2'd0;
  localparam logic [1:0] SEL_Y     = 2'd1;
  localparam logic [1:0] SEL_Z     = 2'd2;
  localparam logic [1:0] SEL_TRACE = 2'd3;

  typedef struct packed {
    logic [1:0]             sel;
    logic                   bad;
    logic [2:0]             neg;
    logic [2:0][MAG_W-1:0]  mag;
  } side_t;

endpackage

// ===== rtl/rmq_ifs.sv =====
interface rmq_mat_if;
  logic                                valid;
  logic                                ready;
  logic signed [rmq_pkg::FIELD_W-1:0]  e_c0_r0;
  logic signed [rmq_pkg::FIELD_W-1:0]  e_c0_r1;
  logic signed [rmq_pkg::FIELD_W-1:0]  e_c0_r2;
  logic signed [rmq_pkg::FIELD_W-1:0]  e_c1_r0;
  logic signed [rmq_pkg::FIELD_W-1:0]  e_c1_r1;
  logic signed [rmq_pkg::FIELD_W-1:0]  e_c1_r2;
  logic signed [rmq_pkg::FIELD_W-1:0]  e_c2_r0;
  logic signed [rmq_pkg::FIELD_W-1:0]  e_c2_r1;
  logic signed [rmq_pkg::FIELD_W-1:0]  e_c2_r2;

  modport source (output valid, e_c0_r0, e_c0_r1, e_c0_r2, e_c1_r0, e_c1_r1, e_c1_r2,
                  e_c2_r0, e_c2_r1, e_c2_r2, input ready);
  modport sink   (input valid, e_c0_r0, e_c0_r1, e_c0_r2, e_c1_r0, e_c1_r1, e_c1_r2,
                  e_c2_r0, e_c2_r1, e_c2_r2, output ready);
endinterface

interface rmq_quat_if;
  logic                                valid;
  logic                                ready;
  logic signed [rmq_pkg::FIELD_W-1:0]  quat_x;
  logic signed [rmq_pkg::FIELD_W-1:0]  quat_y;
  logic signed [rmq_pkg::FIELD_W-1:0]  quat_z;
  logic signed [rmq_pkg::FIELD_W-1:0]  quat_w;
  logic                                bad_root;

  modport source (output valid, quat_x, quat_y, quat_z, quat_w, bad_root, input ready);
  modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, bad_root, output ready);
endinterface

// ===== rtl/rotation_matrix_to_quaternion_top.sv =====
// pipeline: entry register, RW = (AW + FRAC_BITS + 1) / 2 root stages, divider
//   entry register, QW = max(FRAC_BITS + 19, RW) + 1 divide stages, output register
// throughput: one item per cycle; the bit-per-stage root and the three
//   bit-per-stage dividers set the depth, the whole pipe stalls with the output
// reset: rst_ni clears all valid bits at once, no item is in flight afterwards
module rotation_matrix_to_quaternion_top #(
  parameter int unsigned FRAC_BITS = rmq_pkg::FRAC_BITS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  rmq_mat_if.sink        mat_i,
  rmq_quat_if.source     quat_o
);

  localparam int unsigned FW  = rmq_pkg::FIELD_W;
  localparam int unsigned MW  = rmq_pkg::MAG_W;
  localparam int unsigned AW  = ((FRAC_BITS > 18) ? FRAC_BITS : 18) + 3;
  localparam int unsigned RW  = (AW + FRAC_BITS + 1) / 2;
  localparam int unsigned SW  = 2 * RW;
  localparam int unsigned RMW = RW + 3;
  localparam int unsigned QW  = (((MW + FRAC_BITS) > RW) ? (MW + FRAC_BITS) : RW) + 1;
  localparam int unsigned DRW = RW + 2;
  localparam logic signed [AW-1:0] ONE = AW'(1) << FRAC_BITS;

  logic en;
  logic out_v_q;

  assign en          = !out_v_q || quat_o.ready;
  assign mat_i.ready = en;

  // ---------------- entry stage: case select, root argument, numerators
  logic signed [FW+1:0] tr;
  logic                 pos;
  logic [1:0]           isel;
  logic signed [FW-1:0] mii, mjj, mkk, mjk, mkj, mij, mji, mik, mki;
  logic signed [AW-1:0] arg;
  logic signed [FW:0]   d0, d1, d2;
  logic                 bad;
  rmq_pkg::side_t       side_d;
  logic [SW-1:0]        n_d;

  always_comb begin
    tr  = (FW+2)'(mat_i.e_c0_r0) + (FW+2)'(mat_i.e_c1_r1) + (FW+2)'(mat_i.e_c2_r2);
    pos = (tr > 0);
    isel = rmq_pkg::SEL_X;
    if (mat_i.e_c1_r1 > mat_i.e_c0_r0) isel = rmq_pkg::SEL_Y;
    if (isel == rmq_pkg::SEL_Y) begin
      if (mat_i.e_c2_r2 > mat_i.e_c1_r1) isel = rmq_pkg::SEL_Z;
    end else begin
      if (mat_i.e_c2_r2 > mat_i.e_c0_r0) isel = rmq_pkg::SEL_Z;
    end
    case (isel)
      rmq_pkg::SEL_Y: begin
        mii = mat_i.e_c1_r1; mjj = mat_i.e_c2_r2; mkk = mat_i.e_c0_r0;
        mjk = mat_i.e_c2_r0; mkj = mat_i.e_c0_r2;
        mij = mat_i.e_c1_r2; mji = mat_i.e_c2_r1;
        mik = mat_i.e_c1_r0; mki = mat_i.e_c0_r1;
      end
      rmq_pkg::SEL_Z: begin
        mii = mat_i.e_c2_r2; mjj = mat_i.e_c0_r0; mkk = mat_i.e_c1_r1;
        mjk = mat_i.e_c0_r1; mkj = mat_i.e_c1_r0;
        mij = mat_i.e_c2_r0; mji = mat_i.e_c0_r2;
        mik = mat_i.e_c2_r1; mki = mat_i.e_c1_r2;
      end
      default: begin
        mii = mat_i.e_c0_r0; mjj = mat_i.e_c1_r1; mkk = mat_i.e_c2_r2;
        mjk = mat_i.e_c1_r2; mkj = mat_i.e_c2_r1;
        mij = mat_i.e_c0_r1; mji = mat_i.e_c1_r0;
        mik = mat_i.e_c0_r2; mki = mat_i.e_c2_r0;
      end
    endcase
    if (pos) begin
      arg = AW'(tr) + ONE;
      d0  = (FW+1)'(mat_i.e_c1_r2) - (FW+1)'(mat_i.e_c2_r1);
      d1  = (FW+1)'(mat_i.e_c2_r0) - (FW+1)'(mat_i.e_c0_r2);
      d2  = (FW+1)'(mat_i.e_c0_r1) - (FW+1)'(mat_i.e_c1_r0);
    end else begin
      arg = AW'(mii) - AW'(mjj) - AW'(mkk) + ONE;
      d0  = (FW+1)'(mjk) - (FW+1)'(mkj);
      d1  = (FW+1)'(mij) + (FW+1)'(mji);
      d2  = (FW+1)'(mik) + (FW+1)'(mki);
    end
    bad        = (arg <= 0);
    side_d.sel = pos ? rmq_pkg::SEL_TRACE : isel;
    side_d.bad = bad;
    side_d.neg = {d2[FW], d1[FW], d0[FW]};
    side_d.mag[0] = d0[FW] ? MW'(-d0) : MW'(d0);
    side_d.mag[1] = d1[FW] ? MW'(-d1) : MW'(d1);
    side_d.mag[2] = d2[FW] ? MW'(-d2) : MW'(d2);
    n_d = bad ? '0 : (SW'(arg[AW-2:0]) << FRAC_BITS);
  end

  // ---------------- square root, one result bit per stage
  logic [SW-1:0]       sq_n_q    [RW+1];
  logic [RMW-1:0]      sq_rem_q  [RW+1];
  logic [RW-1:0]       sq_root_q [RW+1];
  rmq_pkg::side_t      sq_side_q [RW+1];
  logic [RW:0]         sq_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q[0] <= 1'b0;
    end else if (en) begin
      sq_v_q[0] <= mat_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_n_q[0]    <= n_d;
      sq_rem_q[0]  <= '0;
      sq_root_q[0] <= '0;
      sq_side_q[0] <= side_d;
    end
  end

  for (genvar t = 1; t <= RW; t++) begin : g_sqrt
    logic [RMW-1:0] rem2;
    logic [RMW-1:0] trial;
    logic           fit;

    always_comb begin
      rem2  = {sq_rem_q[t-1][RMW-3:0], sq_n_q[t-1][SW-1 -: 2]};
      trial = RMW'({sq_root_q[t-1], 2'b01});
      fit   = (rem2 >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[t] <= 1'b0;
      end else if (en) begin
        sq_v_q[t] <= sq_v_q[t-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_n_q[t]    <= sq_n_q[t-1] << 2;
        sq_rem_q[t]  <= fit ? (rem2 - trial) : rem2;
        sq_root_q[t] <= {sq_root_q[t-1][RW-2:0], fit};
        sq_side_q[t] <= sq_side_q[t-1];
      end
    end
  end

  // ---------------- three dividers sharing the divisor 2r, one quotient bit per stage
  logic [2:0][QW-1:0]  dv_num_q  [QW+1];
  logic [2:0][DRW-1:0] dv_rem_q  [QW+1];
  logic [2:0][QW-1:0]  dv_quo_q  [QW+1];
  logic [RW-1:0]       dv_r_q    [QW+1];
  rmq_pkg::side_t      dv_side_q [QW+1];
  logic [QW:0]         dv_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (en) begin
      dv_v_q[0] <= sq_v_q[RW];
    end
  end

  // numerator |d| * 2^F + r gives round to nearest, ties away from zero
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int s = 0; s < 3; s++) begin
        dv_num_q[0][s] <= (QW'(sq_side_q[RW].mag[s]) << FRAC_BITS) + QW'(sq_root_q[RW]);
      end
      dv_rem_q[0]  <= '0;
      dv_quo_q[0]  <= '0;
      dv_r_q[0]    <= sq_root_q[RW];
      dv_side_q[0] <= sq_side_q[RW];
    end
  end

  for (genvar u = 1; u <= QW; u++) begin : g_div
    logic [DRW-1:0]      dvs;
    logic [2:0][DRW-1:0] rem2;
    logic [2:0]          fit;

    always_comb begin
      dvs = {1'b0, dv_r_q[u-1], 1'b0};
      for (int s = 0; s < 3; s++) begin
        rem2[s] = {dv_rem_q[u-1][s][DRW-2:0], dv_num_q[u-1][s][QW-1]};
        fit[s]  = (rem2[s] >= dvs);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[u] <= 1'b0;
      end else if (en) begin
        dv_v_q[u] <= dv_v_q[u-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int s = 0; s < 3; s++) begin
          dv_num_q[u][s] <= dv_num_q[u-1][s] << 1;
          dv_rem_q[u][s] <= fit[s] ? (rem2[s] - dvs) : rem2[s];
          dv_quo_q[u][s] <= {dv_quo_q[u-1][s][QW-2:0], fit[s]};
        end
        dv_r_q[u]    <= dv_r_q[u-1];
        dv_side_q[u] <= dv_side_q[u-1];
      end
    end
  end

  // ---------------- sign, saturation, placement
  function automatic logic signed [FW-1:0] sat_signed(input logic [QW-1:0] mag,
                                                      input logic neg);
    logic signed [FW-1:0] res;
    if (neg) begin
      if (mag > QW'(131072)) res = rmq_pkg::SAT_MIN;
      else                   res = FW'(-mag);
    end else begin
      if (mag > QW'(131071)) res = rmq_pkg::SAT_MAX;
      else                   res = FW'(mag);
    end
    return res;
  endfunction

  rmq_pkg::side_t       fs;
  logic [RW:0]          rp1;
  logic signed [FW-1:0] diag, s0, s1, s2;
  logic signed [FW-1:0] qx_d, qy_d, qz_d, qw_d;

  always_comb begin
    fs   = dv_side_q[QW];
    rp1  = (RW+1)'(dv_r_q[QW]) + 1'b1;
    diag = ((rp1 >> 1) > (RW+1)'(131071)) ? rmq_pkg::SAT_MAX : FW'(rp1 >> 1);
    s0   = sat_signed(dv_quo_q[QW][0], fs.neg[0]);
    s1   = sat_signed(dv_quo_q[QW][1], fs.neg[1]);
    s2   = sat_signed(dv_quo_q[QW][2], fs.neg[2]);
    case (fs.sel)
      rmq_pkg::SEL_TRACE: begin qx_d = s0;   qy_d = s1;   qz_d = s2;   qw_d = diag; end
      rmq_pkg::SEL_Y:     begin qx_d = s2;   qy_d = diag; qz_d = s1;   qw_d = s0;   end
      rmq_pkg::SEL_Z:     begin qx_d = s1;   qy_d = s2;   qz_d = diag; qw_d = s0;   end
      default:            begin qx_d = diag; qy_d = s1;   qz_d = s2;   qw_d = s0;   end
    endcase
    if (fs.bad) begin
      qx_d = '0; qy_d = '0; qz_d = '0; qw_d = '0;
    end
  end

  logic signed [FW-1:0] qx_q, qy_q, qz_q, qw_q;
  logic                 bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      qx_q  <= qx_d;
      qy_q  <= qy_d;
      qz_q  <= qz_d;
      qw_q  <= qw_d;
      bad_q <= fs.bad;
    end
  end

  assign quat_o.valid    = out_v_q;
  assign quat_o.quat_x   = qx_q;
  assign quat_o.quat_y   = qy_q;
  assign quat_o.quat_z   = qz_q;
  assign quat_o.quat_w   = qw_q;
  assign quat_o.bad_root = bad_q;

endmodule

// ===== rtl/rmq_checker.sv =====
module rmq_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic signed [rmq_pkg::FIELD_W-1:0] quat_x_i,
  input logic signed [rmq_pkg::FIELD_W-1:0] quat_y_i,
  input logic signed [rmq_pkg::FIELD_W-1:0] quat_z_i,
  input logic signed [rmq_pkg::FIELD_W-1:0] quat_w_i,
  input logic                               bad_root_i
);

  // stalled item holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(quat_x_i) && $stable(quat_y_i)
      && $stable(quat_z_i) && $stable(quat_w_i) && $stable(bad_root_i))
    else $error("output item changed while stalled");

  // an empty output stage never blocks the input
  a_in_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked with empty output");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && bad_root_i |-> quat_x_i == 0 && quat_y_i == 0 && quat_z_i == 0
      && quat_w_i == 0)
    else $error("bad root item with nonzero components");

  // the root term is at least one half lsb up, so some component is positive
  a_root_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !bad_root_i |-> quat_x_i > 0 || quat_y_i > 0 || quat_z_i > 0
      || quat_w_i > 0)
    else $error("good item without a positive component");

endmodule

bind rotation_matrix_to_quaternion_top rmq_checker u_rmq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (mat_i.ready),
  .out_valid_i (quat_o.valid),
  .out_ready_i (quat_o.ready),
  .quat_x_i    (quat_o.quat_x),
  .quat_y_i    (quat_o.quat_y),
  .quat_z_i    (quat_o.quat_z),
  .quat_w_i    (quat_o.quat_w),
  .bad_root_i  (quat_o.bad_root)
);
